[rtl/mbapr_pkg.sv]
// ----------------------------------------------------------------------------
// MBAP receiver package
// Types, codes and sizes shared by the MBAP frame receiver modules.
// ----------------------------------------------------------------------------
package mbapr_pkg;

   localparam int BUFFER_BYTES   = 512;
   localparam int COUNT_WIDTH    = $clog2(BUFFER_BYTES + 1);
   localparam int TOTAL_WIDTH    = 17;
   localparam int OFFSET_WIDTH   = 9;
   localparam int RSP_DATA_WIDTH = 48;

   localparam int PROTO_END_COUNT = 4;
   localparam int LEN_END_COUNT   = 6;
   localparam int UNIT_ID_OFFSET  = 6;
   localparam int HEADER_BYTES    = 6;
   localparam int PDU_BASE        = 7;

   localparam logic CSR_MASTER_MODE    = 1'b0;
   localparam logic CSR_PSEUDO_ADDRESS = 1'b1;

   typedef enum logic [1:0] {
      CMD_RX_BYTE = 2'd0,
      CMD_TIMER   = 2'd1,
      CMD_RELEASE = 2'd2,
      CMD_TAKE    = 2'd3
   } cmd_type;

   typedef enum logic [2:0] {
      MODE_IDLE     = 3'd0,
      MODE_RCV      = 3'd1,
      MODE_COMPLETE = 3'd2,
      MODE_OFF      = 3'd3,
      MODE_ERROR    = 3'd4
   } mode_type;

   typedef struct packed {
      cmd_type    cmd;
      logic [7:0] rx_byte;
      logic       byte_error;
   } item_type;

   typedef struct packed {
      logic       master_mode;
      logic [7:0] pseudo_address;
   } cfg_type;

   typedef struct packed {
      mode_type                rx_status;
      logic                    byte_stored;
      logic [OFFSET_WIDTH-1:0] byte_offset;
      logic [7:0]              captured_byte;
      logic                    frame_done;
      logic [OFFSET_WIDTH-1:0] pdu_length;
      logic [7:0]              source_address;
      logic                    timer_on;
      logic                    overflow;
   } result_type;

endpackage

[rtl/mbapr_deframe.sv]
// ----------------------------------------------------------------------------
// MBAP receiver deframing core
// Holds the receive state and works out the result of one beat.
// ----------------------------------------------------------------------------
module mbapr_deframe (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  mbapr_pkg::item_type   item,
   input  mbapr_pkg::cfg_type    cfg,
   output mbapr_pkg::result_type rslt
);

   mbapr_pkg::mode_type                  mode_ff, mode_in, eff_mode;
   logic [mbapr_pkg::COUNT_WIDTH-1:0]    count_ff, count_in, count_inc;
   logic [mbapr_pkg::TOTAL_WIDTH-1:0]    total_ff, total_in;
   logic [mbapr_pkg::TOTAL_WIDTH-1:0]    count_ext, count_inc_ext, pdu_full;
   logic [7:0]                           unit_ff, unit_in, unit_sel;
   logic [7:0]                           prev_ff, prev_in;
   logic                                 timer_ff, timer_in;
   logic [15:0]                          word;
   logic                                 hold, full, is_byte, start, rcv_byte;
   logic                                 proto_bad, len_done, frame_end;

   assign hold     = (mode_ff == mbapr_pkg::MODE_COMPLETE) || (mode_ff == mbapr_pkg::MODE_OFF);
   assign eff_mode = (item.byte_error && !hold) ? mbapr_pkg::MODE_ERROR : mode_ff;
   assign is_byte  = (item.cmd == mbapr_pkg::CMD_RX_BYTE);

   assign count_ext     = {{(mbapr_pkg::TOTAL_WIDTH - mbapr_pkg::COUNT_WIDTH){1'b0}}, count_ff};
   assign count_inc     = count_ff + 1'b1;
   assign count_inc_ext = {{(mbapr_pkg::TOTAL_WIDTH - mbapr_pkg::COUNT_WIDTH){1'b0}}, count_inc};
   assign full          = count_ext >= mbapr_pkg::TOTAL_WIDTH'(mbapr_pkg::BUFFER_BYTES);
   assign word          = {prev_ff, item.rx_byte};

   assign start    = is_byte && (eff_mode == mbapr_pkg::MODE_IDLE);
   assign rcv_byte = is_byte && (eff_mode == mbapr_pkg::MODE_RCV) && !full;

   assign proto_bad = (count_inc == mbapr_pkg::COUNT_WIDTH'(mbapr_pkg::PROTO_END_COUNT))
                      && (word != 16'h0000);
   assign len_done  = (count_inc == mbapr_pkg::COUNT_WIDTH'(mbapr_pkg::LEN_END_COUNT));
   assign frame_end = (count_inc_ext > mbapr_pkg::TOTAL_WIDTH'(mbapr_pkg::HEADER_BYTES))
                      && (count_inc_ext >= total_ff);
   assign unit_sel  = (count_ff == mbapr_pkg::COUNT_WIDTH'(mbapr_pkg::UNIT_ID_OFFSET))
                      ? item.rx_byte : unit_ff;
   assign pdu_full  = count_inc_ext - mbapr_pkg::TOTAL_WIDTH'(mbapr_pkg::PDU_BASE);

   always_comb begin
      mode_in = mode_ff;
      unique case (item.cmd)
         mbapr_pkg::CMD_RX_BYTE: begin
            if (start) begin
               mode_in = mbapr_pkg::MODE_RCV;
            end else if (eff_mode == mbapr_pkg::MODE_RCV) begin
               if (full) begin
                  mode_in = mbapr_pkg::MODE_ERROR;
               end else if (proto_bad) begin
                  mode_in = mbapr_pkg::MODE_IDLE;
               end else if (frame_end) begin
                  mode_in = mbapr_pkg::MODE_COMPLETE;
               end else begin
                  mode_in = mbapr_pkg::MODE_RCV;
               end
            end else begin
               mode_in = eff_mode;
            end
         end
         mbapr_pkg::CMD_TIMER: begin
            mode_in = hold ? mode_ff : mbapr_pkg::MODE_IDLE;
         end
         mbapr_pkg::CMD_RELEASE: begin
            mode_in = hold ? mbapr_pkg::MODE_IDLE : mode_ff;
         end
         mbapr_pkg::CMD_TAKE: begin
            mode_in = (hold || (mode_ff == mbapr_pkg::MODE_IDLE)) ? mbapr_pkg::MODE_OFF
                                                                   : mode_ff;
         end
         default: begin
            mode_in = mode_ff;
         end
      endcase
   end

   always_comb begin
      count_in = count_ff;
      total_in = total_ff;
      unit_in  = unit_ff;
      prev_in  = prev_ff;
      timer_in = timer_ff;
      rslt     = '0;
      if (start) begin
         count_in           = mbapr_pkg::COUNT_WIDTH'(1);
         prev_in            = item.rx_byte;
         timer_in           = 1'b1;
         rslt.byte_stored   = 1'b1;
         rslt.captured_byte = item.rx_byte;
      end
      if (rcv_byte) begin
         rslt.byte_stored   = 1'b1;
         rslt.byte_offset   = count_ext[mbapr_pkg::OFFSET_WIDTH-1:0];
         rslt.captured_byte = item.rx_byte;
         count_in           = count_inc;
         prev_in            = item.rx_byte;
         unit_in            = unit_sel;
         if (proto_bad) begin
            timer_in = 1'b0;
         end else if (len_done) begin
            total_in = {1'b0, word} + mbapr_pkg::TOTAL_WIDTH'(mbapr_pkg::HEADER_BYTES);
         end else if (frame_end) begin
            timer_in            = 1'b0;
            rslt.frame_done     = 1'b1;
            rslt.pdu_length     = pdu_full[mbapr_pkg::OFFSET_WIDTH-1:0];
            rslt.source_address = cfg.master_mode ? unit_sel : cfg.pseudo_address;
         end
      end
      if (is_byte && (eff_mode == mbapr_pkg::MODE_RCV) && full) begin
         rslt.overflow = 1'b1;
      end
      if (item.cmd == mbapr_pkg::CMD_TIMER) begin
         timer_in = 1'b0;
      end
      rslt.rx_status = mode_in;
      rslt.timer_on  = timer_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= mbapr_pkg::MODE_IDLE;
         count_ff <= '0;
         total_ff <= '0;
         unit_ff  <= '0;
         prev_ff  <= '0;
         timer_ff <= 1'b0;
      end else if (step) begin
         mode_ff  <= mode_in;
         count_ff <= count_in;
         total_ff <= total_in;
         unit_ff  <= unit_in;
         prev_ff  <= prev_in;
         timer_ff <= timer_in;
      end
   end

endmodule

[rtl/mbap_frame_receiver.sv]
// ----------------------------------------------------------------------------
// MBAP frame receiver
// Receive side of a Modbus TCP deframer: checks the MBAP header, counts the
// frame and reports completion, PDU length and source address per beat.
// ----------------------------------------------------------------------------
//  Channel | Direction | Contents
//  req_*   | in        | tdata: rx_byte; tuser: cmd, byte_error
//  rsp_*   | out       | tdata: one result per request beat
//  csr_*   | in        | register writes: master_mode, pseudo_address
//
// Each request beat passes through the input register and then the result
// register, and one beat is taken every cycle while the result is not
// stalled. The frame state advances as a beat moves into the result register.
// A stalled result holds the pipeline; reset is synchronous and clears the
// valid flags of both stages and the frame state.
// ----------------------------------------------------------------------------
module mbap_frame_receiver (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [7:0]                           req_tdata,  // [7:0] rx_byte
   input  logic [2:0]                           req_tuser,  // [1:0] cmd, [2] byte_error
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [2:0] rx_status, [3] byte_stored, [12:4] byte_offset, [20:13] captured_byte,
   // [21] frame_done, [30:22] pdu_length, [38:31] source_address, [39] timer_on,
   // [40] overflow, [47:41] zero
   output logic [mbapr_pkg::RSP_DATA_WIDTH-1:0] rsp_tdata,
   input  logic                                 csr_we,
   input  logic                                 csr_index,
   input  logic [7:0]                           csr_wdata
);

   logic                                 s1_valid_ff, s1_valid_in;
   mbapr_pkg::item_type                  s1_item_ff;
   logic                                 rsp_valid_ff, rsp_valid_in;
   logic [mbapr_pkg::RSP_DATA_WIDTH-1:0] rsp_data_ff;
   mbapr_pkg::cfg_type                   cfg_ff;
   mbapr_pkg::result_type                rslt;
   logic                                 out_ready, step, accept;

   assign out_ready  = !rsp_valid_ff || rsp_tready;
   assign step       = s1_valid_ff && out_ready;
   assign req_tready = !s1_valid_ff || out_ready;
   assign accept     = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (accept) begin
         s1_valid_in = 1'b1;
      end else if (step) begin
         s1_valid_in = 1'b0;
      end
      rsp_valid_in = rsp_valid_ff;
      if (step) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_item_ff.cmd        <= mbapr_pkg::cmd_type'(req_tuser[1:0]);
         s1_item_ff.rx_byte    <= req_tdata;
         s1_item_ff.byte_error <= req_tuser[2];
      end
      if (step) begin
         rsp_data_ff <= {7'b0, rslt.overflow, rslt.timer_on, rslt.source_address,
                         rslt.pdu_length, rslt.frame_done, rslt.captured_byte,
                         rslt.byte_offset, rslt.byte_stored, rslt.rx_status};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.master_mode    <= 1'b0;
         cfg_ff.pseudo_address <= 8'hFF;
      end else if (csr_we) begin
         unique case (csr_index)
            mbapr_pkg::CSR_MASTER_MODE:    cfg_ff.master_mode    <= csr_wdata[0];
            mbapr_pkg::CSR_PSEUDO_ADDRESS: cfg_ff.pseudo_address <= csr_wdata;
            default:                       cfg_ff                <= cfg_ff;
         endcase
      end
   end

   mbapr_deframe u_deframe (
      .clock (clock),
      .reset (reset),
      .step  (step),
      .item  (s1_item_ff),
      .cfg   (cfg_ff),
      .rslt  (rslt)
   );

endmodule
